[hw/rtl/plrl_pkg.sv]
// Shared types, constants and codes of the rate-limited position loop.
package plrl_pkg;

    // Field formats
    localparam int POS_W       = 32;
    localparam int SPD_FRAC    = 16;
    localparam int SPD_W       = 8 + SPD_FRAC;
    localparam int GAIN_W      = 24;
    localparam int GAIN_FRAC   = 24;
    localparam int COEFF_W     = 17;
    localparam int SMOOTH_FRAC = 16;
    localparam int MAXSPD_W    = 7;
    localparam int MAXACC_W    = 23;
    localparam int BAND_W      = 16;
    localparam int REGIME_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_VAL_W   = 24;

    // Datapath widths
    localparam int MAG_W         = POS_W;
    localparam int HALF_W        = MAG_W / 2;
    localparam int PROD_SHIFT    = GAIN_FRAC - SPD_FRAC;
    localparam int PROD_CAP_EXP  = 40;
    localparam int PROD_W        = MAG_W + GAIN_W;
    localparam int TERM_W        = PROD_CAP_EXP + 2;
    localparam int RAW_W         = TERM_W + 1;
    localparam int MUL_A_W       = ((COEFF_W > MAG_W - HALF_W) ? COEFF_W : MAG_W - HALF_W) + 1;
    localparam int MUL_B_W       = ((GAIN_W > SPD_W) ? GAIN_W : SPD_W) + 1;
    localparam int MUL_P_W       = MUL_A_W + MUL_B_W;
    localparam int FILT_W        = MUL_P_W + 1;

    localparam logic [PROD_W-1:0] PROD_CAP =
        {{(PROD_W-PROD_CAP_EXP-1){1'b0}}, 1'b1, {PROD_CAP_EXP{1'b0}}};
    localparam logic [COEFF_W-1:0] COEFF_ONE =
        {{(COEFF_W-SMOOTH_FRAC-1){1'b0}}, 1'b1, {SMOOTH_FRAC{1'b0}}};
    localparam logic signed [SPD_W-1:0] SPD_MAX = {1'b0, {(SPD_W-1){1'b1}}};
    localparam logic signed [SPD_W-1:0] SPD_MIN = {1'b1, {(SPD_W-1){1'b0}}};

    typedef enum logic [REGIME_W-1:0] {
        REGIME_FAR  = 2'd0,
        REGIME_NEAR = 2'd1,
        REGIME_DEAD = 2'd2
    } plrl_regime_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_GAIN      = 3'd0,
        REG_KI_GAIN      = 3'd1,
        REG_KD_GAIN      = 3'd2,
        REG_SPEED_CAP    = 3'd3,
        REG_MAX_ACC      = 3'd4,
        REG_SMOOTH_COEFF = 3'd5,
        REG_FAR_BAND     = 3'd6,
        REG_NEAR_BAND    = 3'd7
    } plrl_reg_idx_t;

    typedef struct packed {
        logic signed [POS_W-1:0] measured_position;
        logic signed [POS_W-1:0] target_position;
    } plrl_sample_t;

    typedef struct packed {
        logic signed [SPD_W-1:0] speed_command;
        logic [REGIME_W-1:0]     regime;
        logic                    accel_limited;
        logic                    speed_limited;
    } plrl_command_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_VAL_W-1:0] value;
    } plrl_cfg_wr_t;

    typedef struct packed {
        logic [GAIN_W-1:0]   kp_gain;
        logic [GAIN_W-1:0]   ki_gain;
        logic [GAIN_W-1:0]   kd_gain;
        logic [MAXSPD_W-1:0] speed_cap;
        logic [MAXACC_W-1:0] max_acc;
        logic [COEFF_W-1:0]  smooth_coeff;
        logic [BAND_W-1:0]   far_band;
        logic [BAND_W-1:0]   near_band;
    } plrl_cfg_t;

    localparam plrl_cfg_t CFG_RESET = '{
        kp_gain:      24'd53687,
        ki_gain:      24'd218,
        kd_gain:      24'd252,
        speed_cap:    7'd21,
        max_acc:      23'd48497,
        smooth_coeff: 17'd42992,
        far_band:     16'd300,
        near_band:    16'd10
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_BAND,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_ACC,
        ST_TERM_ADD,
        ST_FILT_A,
        ST_FILT_B,
        ST_FILT_SUM,
        ST_ACCEL,
        ST_CLAMP
    } plrl_state_t;

    typedef enum logic [1:0] {
        MSEL_MAG_LO,
        MSEL_MAG_HI,
        MSEL_FILT_NEW,
        MSEL_FILT_OLD
    } plrl_mul_sel_t;

    typedef struct packed {
        logic          idle;
        logic          calc_err;
        logic          calc_band;
        logic          mul_en;
        plrl_mul_sel_t mul_sel;
        logic          term_b;
        logic          prod_load;
        logic          prod_acc;
        logic          term_add;
        logic          filt_load;
        logic          filt_acc;
        logic          accel;
        logic          finish;
    } plrl_ctl_t;

    typedef struct packed {
        logic in_fire;
        logic dead;
        logic out_free;
    } plrl_stat_t;

endpackage

[hw/rtl/plrl_stream_if.sv]
// Valid/ready channel carrying one payload of type T.
interface plrl_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/position_loop_rate_limited.sv]
// Position loop with PD / incremental regimes, smoothing filter and rate limits.
//
//  channel  | dir  | payload                                              | ready
//  sample   | in   | measured_position, target_position                   | high when idle
//  command  | out  | speed_command, regime, accel_limited, speed_limited  | from consumer
//  regs     | in   | index, value                                         | always high
//
// In the far and near regimes an item takes two gain products, each two 16-bit
// passes through the single 18x25 multiplier, then two filter products; in the
// dead band it takes only the two filter products. The result is loaded into the
// output register in the last step, and only then is the next sample accepted;
// a stalled consumer holds the sequencer in its last step only.
// Reset clears the sequencer, the loop history and the output valid flag.
module position_loop_rate_limited (
    input  logic          clk,
    input  logic          rst_n,
    plrl_stream_if.sink   sample,
    plrl_stream_if.source command,
    plrl_stream_if.sink   regs
);
    import plrl_pkg::*;

    plrl_cfg_t  cfg;
    plrl_ctl_t  ctl;
    plrl_stat_t stat;

    logic signed [POS_W-1:0]   meas_reg;
    logic signed [POS_W-1:0]   targ_reg;
    logic signed [POS_W-1:0]   err_reg;
    logic signed [POS_W-1:0]   prev_err_reg;
    logic signed [POS_W:0]     delta_reg;
    logic [MAG_W-1:0]          mag_a_reg;
    logic [MAG_W-1:0]          mag_b_reg;
    logic                      neg_a_reg;
    logic                      neg_b_reg;
    plrl_regime_t              regime_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic signed [RAW_W-1:0]   raw_reg;
    logic signed [FILT_W-1:0]  filt_reg;
    logic signed [SPD_W-1:0]   prev_spd_reg;
    logic signed [SPD_W+1:0]   spd_a_reg;
    logic                      acc_flag_reg;
    plrl_command_t             out_reg;
    logic                      out_valid_reg;

    logic signed [POS_W:0]     diff;
    logic signed [POS_W-1:0]   err_sat;
    logic signed [POS_W:0]     delta;
    logic signed [POS_W:0]     delta_neg;
    logic [MAG_W-1:0]          mag_a;
    plrl_regime_t              regime_now;
    logic [MAG_W-1:0]          mag_sel;
    logic [GAIN_W-1:0]         gain_sel;
    logic                      far_sel;
    logic [COEFF_W-1:0]        coeff;
    logic [COEFF_W-1:0]        coeff_old;
    logic                      raw_fits;
    logic signed [SPD_W-1:0]   raw_sat;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic [PROD_W-1:0]         prod_shift;
    logic [PROD_W-1:0]         prod_capped;
    logic signed [TERM_W-1:0]  term_mag;
    logic signed [TERM_W-1:0]  term_val;
    logic signed [SPD_W-1:0]   filt_val;
    logic signed [SPD_W:0]     max_acc_s;
    logic signed [SPD_W:0]     acc_raw;
    logic signed [SPD_W:0]     acc_lim;
    logic                      acc_flag;
    logic signed [SPD_W+1:0]   spd_lim;
    logic signed [SPD_W+1:0]   spd_c;
    logic                      spd_flag;

    plrl_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (regs.valid),
        .wr    (regs.data),
        .cfg   (cfg)
    );

    plrl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    plrl_mul u_mul (
        .clk (clk),
        .en  (ctl.mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign regs.ready     = 1'b1;
    assign sample.ready   = ctl.idle;
    assign command.valid  = out_valid_reg;
    assign command.data   = out_reg;

    assign stat.in_fire  = sample.valid && sample.ready;
    assign stat.dead     = (regime_now == REGIME_DEAD);
    assign stat.out_free = !out_valid_reg || command.ready;

    // Position error, saturated to the position range
    assign diff    = {targ_reg[POS_W-1], targ_reg} - {meas_reg[POS_W-1], meas_reg};
    assign err_sat = (diff[POS_W] == diff[POS_W-1]) ? diff[POS_W-1:0]
                   : {diff[POS_W], {(POS_W-1){~diff[POS_W]}}};

    assign delta     = {err_reg[POS_W-1], err_reg} - {prev_err_reg[POS_W-1], prev_err_reg};
    assign delta_neg = -delta_reg;
    assign mag_a     = err_reg[POS_W-1] ? $unsigned(-err_reg) : $unsigned(err_reg);

    always_comb
    begin
        if (mag_a > MAG_W'(cfg.far_band))
        begin
            regime_now = REGIME_FAR;
        end
        else if (mag_a > MAG_W'(cfg.near_band))
        begin
            regime_now = REGIME_NEAR;
        end
        else
        begin
            regime_now = REGIME_DEAD;
        end
    end

    // Far: kp*err + kd*delta.  Near: ki*err + kp*delta on top of the last speed.
    assign far_sel  = (regime_reg == REGIME_FAR);
    assign mag_sel  = ctl.term_b ? mag_b_reg : mag_a_reg;
    assign gain_sel = far_sel ? (ctl.term_b ? cfg.kd_gain : cfg.kp_gain)
                              : (ctl.term_b ? cfg.kp_gain : cfg.ki_gain);

    assign coeff     = (cfg.smooth_coeff > COEFF_ONE) ? COEFF_ONE : cfg.smooth_coeff;
    assign coeff_old = COEFF_ONE - coeff;

    assign raw_fits = (raw_reg[RAW_W-1:SPD_W-1] == '0) || (raw_reg[RAW_W-1:SPD_W-1] == '1);
    assign raw_sat  = raw_fits ? raw_reg[SPD_W-1:0] : (raw_reg[RAW_W-1] ? SPD_MIN : SPD_MAX);

    always_comb
    begin
        case (ctl.mul_sel)
            MSEL_MAG_LO:
            begin
                mul_a = $signed(MUL_A_W'(mag_sel[HALF_W-1:0]));
                mul_b = $signed(MUL_B_W'(gain_sel));
            end
            MSEL_MAG_HI:
            begin
                mul_a = $signed(MUL_A_W'(mag_sel[MAG_W-1:HALF_W]));
                mul_b = $signed(MUL_B_W'(gain_sel));
            end
            MSEL_FILT_NEW:
            begin
                mul_a = $signed(MUL_A_W'(coeff));
                mul_b = MUL_B_W'(raw_sat);
            end
            MSEL_FILT_OLD:
            begin
                mul_a = $signed(MUL_A_W'(coeff_old));
                mul_b = MUL_B_W'(prev_spd_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Drop the extra gain fraction bits, hold the magnitude at the product cap
    assign prod_shift  = prod_reg >> PROD_SHIFT;
    assign prod_capped = (prod_shift > PROD_CAP) ? PROD_CAP : prod_shift;
    assign term_mag    = $signed(prod_capped[TERM_W-1:0]);
    assign term_val    = (ctl.term_b ? neg_b_reg : neg_a_reg) ? -term_mag : term_mag;

    assign filt_val  = filt_reg[SMOOTH_FRAC+SPD_W-1:SMOOTH_FRAC];
    assign max_acc_s = $signed((SPD_W+1)'(cfg.max_acc));
    assign acc_raw   = (SPD_W+1)'(filt_val) - (SPD_W+1)'(prev_spd_reg);

    always_comb
    begin
        acc_lim  = acc_raw;
        acc_flag = 1'b0;
        if (acc_raw > max_acc_s)
        begin
            acc_lim  = max_acc_s;
            acc_flag = 1'b1;
        end
        else if (acc_raw < -max_acc_s)
        begin
            acc_lim  = -max_acc_s;
            acc_flag = 1'b1;
        end
    end

    assign spd_lim = $signed((SPD_W+2)'({cfg.speed_cap, {SPD_FRAC{1'b0}}}));

    always_comb
    begin
        spd_c    = spd_a_reg;
        spd_flag = 1'b0;
        if (spd_a_reg > spd_lim)
        begin
            spd_c    = spd_lim;
            spd_flag = 1'b1;
        end
        else if (spd_a_reg < -spd_lim)
        begin
            spd_c    = -spd_lim;
            spd_flag = 1'b1;
        end
    end

    // Datapath payload registers
    always_ff @(posedge clk)
    begin
        if (stat.in_fire)
        begin
            meas_reg <= sample.data.measured_position;
            targ_reg <= sample.data.target_position;
        end
        if (ctl.calc_err)
        begin
            err_reg <= err_sat;
        end
        if (ctl.calc_band)
        begin
            delta_reg  <= delta;
            mag_a_reg  <= mag_a;
            neg_a_reg  <= err_reg[POS_W-1];
            regime_reg <= regime_now;
            raw_reg    <= (regime_now == REGIME_NEAR) ? RAW_W'(prev_spd_reg) : '0;
        end
        if (ctl.prod_load && !ctl.term_b)
        begin
            mag_b_reg <= delta_reg[POS_W] ? delta_neg[MAG_W-1:0] : delta_reg[MAG_W-1:0];
            neg_b_reg <= delta_reg[POS_W];
        end
        if (ctl.prod_load)
        begin
            prod_reg <= PROD_W'($unsigned(mul_p));
        end
        else if (ctl.prod_acc)
        begin
            prod_reg <= prod_reg + (PROD_W'($unsigned(mul_p)) << HALF_W);
        end
        if (ctl.term_add)
        begin
            raw_reg <= raw_reg + RAW_W'(term_val);
        end
        if (ctl.filt_load)
        begin
            filt_reg <= FILT_W'(mul_p);
        end
        else if (ctl.filt_acc)
        begin
            filt_reg <= filt_reg + FILT_W'(mul_p);
        end
        if (ctl.accel)
        begin
            spd_a_reg    <= (SPD_W+2)'(prev_spd_reg) + (SPD_W+2)'(acc_lim);
            acc_flag_reg <= acc_flag;
        end
        if (ctl.finish)
        begin
            out_reg.speed_command <= spd_c[SPD_W-1:0];
            out_reg.regime        <= regime_reg;
            out_reg.accel_limited <= acc_flag_reg;
            out_reg.speed_limited <= spd_flag;
        end
    end

    // Loop history and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_spd_reg  <= '0;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.finish)
            begin
                prev_spd_reg  <= spd_c[SPD_W-1:0];
                prev_err_reg  <= err_reg;
                out_valid_reg <= 1'b1;
            end
            else if (command.valid && command.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end
endmodule

[hw/rtl/plrl_cfg_regs.sv]
// Configuration register file with decode of the write index.
module plrl_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  plrl_pkg::plrl_cfg_wr_t wr,
    output plrl_pkg::plrl_cfg_t  cfg
);
    import plrl_pkg::*;

    plrl_cfg_t cfg_reg;
    plrl_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (plrl_reg_idx_t'(wr.index))
                REG_KP_GAIN:      cfg_next.kp_gain      = wr.value[GAIN_W-1:0];
                REG_KI_GAIN:      cfg_next.ki_gain      = wr.value[GAIN_W-1:0];
                REG_KD_GAIN:      cfg_next.kd_gain      = wr.value[GAIN_W-1:0];
                REG_SPEED_CAP:    cfg_next.speed_cap    = wr.value[MAXSPD_W-1:0];
                REG_MAX_ACC:      cfg_next.max_acc      = wr.value[MAXACC_W-1:0];
                REG_SMOOTH_COEFF: cfg_next.smooth_coeff = wr.value[COEFF_W-1:0];
                REG_FAR_BAND:     cfg_next.far_band     = wr.value[BAND_W-1:0];
                REG_NEAR_BAND:    cfg_next.near_band    = wr.value[BAND_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

[hw/rtl/plrl_mul.sv]
// Shared signed multiplier with registered product.
module plrl_mul (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [plrl_pkg::MUL_A_W-1:0]    a,
    input  logic signed [plrl_pkg::MUL_B_W-1:0]    b,
    output logic signed [plrl_pkg::MUL_P_W-1:0]    p
);
    import plrl_pkg::*;

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;
endmodule

[hw/rtl/plrl_ctrl.sv]
// Sequencer that steps one control tick through the shared multiplier.
module plrl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  plrl_pkg::plrl_stat_t stat,
    output plrl_pkg::plrl_ctl_t  ctl
);
    import plrl_pkg::*;

    plrl_state_t state_reg;
    plrl_state_t state_next;
    logic        term_reg;
    logic        term_next;

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (stat.in_fire)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:      state_next = ST_BAND;
            ST_BAND:
            begin
                term_next  = 1'b0;
                state_next = stat.dead ? ST_FILT_A : ST_MUL_LO;
            end
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_MUL_ACC;
            ST_MUL_ACC:  state_next = ST_TERM_ADD;
            ST_TERM_ADD:
            begin
                term_next  = 1'b1;
                state_next = term_reg ? ST_FILT_A : ST_MUL_LO;
            end
            ST_FILT_A:   state_next = ST_FILT_B;
            ST_FILT_B:   state_next = ST_FILT_SUM;
            ST_FILT_SUM: state_next = ST_ACCEL;
            ST_ACCEL:    state_next = ST_CLAMP;
            ST_CLAMP:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ctl.mul_sel = MSEL_MAG_LO;
        ctl.term_b  = term_reg;
        unique case (state_reg)
            ST_IDLE:     ctl.idle = 1'b1;
            ST_ERR:      ctl.calc_err = 1'b1;
            ST_BAND:     ctl.calc_band = 1'b1;
            ST_MUL_LO:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MSEL_MAG_LO;
            end
            ST_MUL_HI:
            begin
                ctl.mul_en    = 1'b1;
                ctl.mul_sel   = MSEL_MAG_HI;
                ctl.prod_load = 1'b1;
            end
            ST_MUL_ACC:  ctl.prod_acc = 1'b1;
            ST_TERM_ADD: ctl.term_add = 1'b1;
            ST_FILT_A:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MSEL_FILT_NEW;
            end
            ST_FILT_B:
            begin
                ctl.mul_en    = 1'b1;
                ctl.mul_sel   = MSEL_FILT_OLD;
                ctl.filt_load = 1'b1;
            end
            ST_FILT_SUM: ctl.filt_acc = 1'b1;
            ST_ACCEL:    ctl.accel = 1'b1;
            ST_CLAMP:    ctl.finish = stat.out_free;
            default:     ctl.idle = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            term_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end
endmodule

[hw/rtl/plrl_checker.sv]
// Port-level checks of the position loop, bound to the top level.
module plrl_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    cmd_valid,
    input logic                    cmd_ready,
    input plrl_pkg::plrl_command_t cmd_data
);
    import plrl_pkg::*;

    // one transaction at a time on the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a tick is in progress");

    // a result appears only at the end of a busy sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd_valid) |-> !$past(in_ready))
        else $error("result produced without a tick in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_data))
        else $error("stalled result changed or dropped");

    // a speed-clamped command sits on a whole speed unit
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_data.speed_limited |-> cmd_data.speed_command[SPD_FRAC-1:0] == '0)
        else $error("speed clamp left fraction bits set");
endmodule

bind position_loop_rate_limited plrl_checker u_plrl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .cmd_valid (command.valid),
    .cmd_ready (command.ready),
    .cmd_data  (command.data)
);
